>>> rtl/bmo_pkg.sv
// Shared types and constants for the bit matrix orientation map.
`default_nettype none

package bmo_pkg;

  localparam int unsigned MAX_DIM_DEF = 256;

  // field widths
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned ANG_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [ANG_W-1:0] DEG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] DEG_180 = ANG_W'(180);
  localparam logic [ANG_W-1:0] DEG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] DEG_360 = ANG_W'(360);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] BANK_LEFT  = 2'd1;
  localparam logic [1:0] BANK_RIGHT = 2'd2;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_ROWS,
    CFG_SOURCE_COLS,
    CFG_ROTATION_DEG,
    CFG_BANK_SELECT,
    CFG_MIRROR_X,
    CFG_MIRROR_Y,
    CFG_INVERT_BITS,
    CFG_COMPAT_MODE
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] source_rows;
    logic [DIM_W-1:0] source_cols;
    logic [DIM_W-1:0] rotation_deg;
    logic [1:0]       bank_select;
    logic             mirror_x;
    logic             mirror_y;
    logic             invert_bits;
    logic             compat_mode;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic               bit_in;
  } in_item_t;

  typedef struct packed {
    logic             bit_out;
    logic             in_range;
    logic [DIM_W-1:0] out_rows;
    logic [DIM_W-1:0] out_cols;
  } out_item_t;

  // mapper status toward the top level
  typedef struct packed {
    logic             ok;
    logic             in_store;
    logic [DIM_W-1:0] out_rows;
    logic [DIM_W-1:0] out_cols;
  } map_res_t;

endpackage

`default_nettype wire

>>> rtl/bmo_map.sv
// Coordinate mapper: output view coordinate to source store address.
`default_nettype none

module bmo_map #(
  parameter int unsigned MAX_DIM = bmo_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  bmo_pkg::cfg_t     cfg,
  input  bmo_pkg::in_item_t item,
  output bmo_pkg::map_res_t res,
  output logic [ADDR_W-1:0] addr
);
  import bmo_pkg::*;

  localparam logic [DIM_W-1:0] DIM_SAT = (MAX_DIM > 511) ? '1 : DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] rows, cols, r_dim, cf_dim, c_dim;
  logic [DIM_W-1:0] r9, c9, rm, cm, cb, sr, sc, ar, ac;
  logic [ANG_W-1:0] ang_a, ang_b, ang_c;
  rot_t             rot;
  logic             swap, half, ok, in_store;

  always_comb begin
    rows = (cfg.source_rows == '0) ? DIM_W'(1) :
           (cfg.source_rows > DIM_SAT) ? DIM_SAT : cfg.source_rows;
    cols = (cfg.source_cols == '0) ? DIM_W'(1) :
           (cfg.source_cols > DIM_SAT) ? DIM_SAT : cfg.source_cols;

    // angle mod 360, optional extra half turn, then decode
    ang_a = {1'b0, cfg.rotation_deg};
    if (ang_a >= DEG_360) begin
      ang_a = ang_a - DEG_360;
    end
    ang_b = (cfg.compat_mode && cfg.mirror_x) ? ang_a + DEG_180 : ang_a;
    ang_c = (ang_b >= DEG_360) ? ang_b - DEG_360 : ang_b;
    if (ang_c == DEG_90) begin
      rot = ROT_90;
    end else if (ang_c == DEG_180) begin
      rot = ROT_180;
    end else if (ang_c == DEG_270) begin
      rot = ROT_270;
    end else begin
      rot = ROT_0;
    end

    swap   = (rot == ROT_90) || (rot == ROT_270);
    r_dim  = swap ? cols : rows;
    cf_dim = swap ? rows : cols;
    half   = (cfg.bank_select == BANK_LEFT) || (cfg.bank_select == BANK_RIGHT);
    c_dim  = half ? (cf_dim >> 1) : cf_dim;

    r9 = {1'b0, item.row_index};
    c9 = {1'b0, item.col_index};
    ok = (r9 < r_dim) && (c9 < c_dim);

    rm = cfg.mirror_y ? r_dim - DIM_W'(1) - r9 : r9;
    cm = cfg.mirror_x ? c_dim - DIM_W'(1) - c9 : c9;
    cb = (cfg.bank_select == BANK_RIGHT) ? cm + c_dim : cm;

    case (rot)
      ROT_90:  begin sr = cf_dim - DIM_W'(1) - cb; sc = rm; end
      ROT_180: begin sr = r_dim - DIM_W'(1) - rm;  sc = cf_dim - DIM_W'(1) - cb; end
      ROT_270: begin sr = cb; sc = r_dim - DIM_W'(1) - rm; end
      default: begin sr = rm; sc = cb; end
    endcase

    // loads address the store directly
    ar = (item.opcode == OP_READ) ? sr : r9;
    ac = (item.opcode == OP_READ) ? sc : c9;
    in_store = (32'(ar) < MAX_DIM) && (32'(ac) < MAX_DIM);
    addr = in_store ? ADDR_W'(32'(ar) * MAX_DIM + 32'(ac)) : '0;

    res.ok       = ok;
    res.in_store = in_store;
    res.out_rows = r_dim;
    res.out_cols = c_dim;
  end

endmodule

`default_nettype wire

>>> rtl/bmo_store.sv
// Single-port bit store with registered read data.
`default_nettype none

module bmo_store #(
  parameter int unsigned MAX_DIM = bmo_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic              wr_bit,
  output logic              rd_bit
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bit_matrix_orientation_map_core.sv
// Top level of the bit matrix orientation map.
//
// Request channel (req_valid/req_stall/req_data): a load request stores
// bit_in at (row_index, col_index) of the source matrix and returns nothing;
// a read request names a coordinate of the rotated, banked and mirrored view
// and returns one response on rsp_valid/rsp_stall/rsp_data.
// Configuration (cfg_we/cfg_index/cfg_data) writes one register per cycle;
// write it only while no request is in flight.
// A read goes from the input register to the response register and store read
// port. Throughput: one request per cycle unless a read waits on a stalled
// response; the single store port serves one load or one read each cycle.
// Reset clears the configuration to its defaults (1x1 source, no rotation,
// no banking, no mirror, no inversion) and empties the pipeline. Store
// contents are not cleared; read only cells that were loaded.
// When the receiver stalls, the response holds; the input register still
// takes a request if it is empty, and loads keep draining past a stalled
// response since they produce none.
`default_nettype none

module bit_matrix_orientation_map_core #(
  parameter int unsigned MAX_DIM = bmo_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // requests
  input  logic                                req_valid,
  output logic                                req_stall,
  input  bmo_pkg::in_item_t                   req_data,
  // responses
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output bmo_pkg::out_item_t                  rsp_data,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [bmo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmo_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bmo_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  cfg_t cfg, cfg_next;

  // stage 0: input register
  logic     s0_valid;
  in_item_t s0_item;
  logic     s0_adv, s0_load, s0_read, s1_take;

  // stage 1: response register (store read data lives in the store)
  logic             s1_ok, s1_inv;
  logic [DIM_W-1:0] s1_rows, s1_cols;
  logic             mem_q;

  map_res_t          map_res;
  logic [ADDR_W-1:0] map_addr;
  logic              wr_en;

  // configuration registers
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SOURCE_ROWS:  cfg_next.source_rows  = cfg_data;
        CFG_SOURCE_COLS:  cfg_next.source_cols  = cfg_data;
        CFG_ROTATION_DEG: cfg_next.rotation_deg = cfg_data;
        CFG_BANK_SELECT:  cfg_next.bank_select  = cfg_data[1:0];
        CFG_MIRROR_X:     cfg_next.mirror_x     = cfg_data[0];
        CFG_MIRROR_Y:     cfg_next.mirror_y     = cfg_data[0];
        CFG_INVERT_BITS:  cfg_next.invert_bits  = cfg_data[0];
        CFG_COMPAT_MODE:  cfg_next.compat_mode  = cfg_data[0];
        default:          cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{source_rows: DIM_W'(1), source_cols: DIM_W'(1), default: '0};
    end else begin
      cfg <= cfg_next;
    end
  end

  // pipeline control: loads leave stage 0 freely, reads need a free
  // response slot
  assign s0_load   = s0_valid && (s0_item.opcode == OP_LOAD);
  assign s0_read   = s0_valid && (s0_item.opcode == OP_READ);
  assign s0_adv    = s0_load || (s0_read && (!rsp_valid || !rsp_stall));
  assign s1_take   = s0_read && s0_adv;
  assign req_stall = s0_valid && !s0_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!req_stall) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s0_item <= req_data;
    end
  end

  bmo_map #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_map (
    .cfg  (cfg),
    .item (s0_item),
    .res  (map_res),
    .addr (map_addr)
  );

  // loads outside the store are dropped
  assign wr_en = s0_load && map_res.in_store;

  bmo_store #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .rd_en  (s1_take),
    .addr   (map_addr),
    .wr_bit (s0_item.bit_in),
    .rd_bit (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_ok   <= map_res.ok;
      s1_inv  <= cfg.invert_bits;
      s1_rows <= map_res.out_rows;
      s1_cols <= map_res.out_cols;
    end
  end

  // out-of-range reads report 0 regardless of inversion
  assign rsp_data.bit_out  = s1_ok & (mem_q ^ s1_inv);
  assign rsp_data.in_range = s1_ok;
  assign rsp_data.out_rows = s1_rows;
  assign rsp_data.out_cols = s1_cols;

  // a read leaving stage 0 always lands in the response register
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    s1_take |=> rsp_valid)
    else $error("read request lost between stages");

  // the single store port never writes and reads in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && s1_take))
    else $error("store write and read collide");

  // stall only ever holds an occupied input register
  a_stall_occ: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s0_valid)
    else $error("request stalled with empty input register");

  // out-of-range responses carry a zero bit
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.in_range) |-> !rsp_data.bit_out)
    else $error("out-of-range response carries a set bit");

  // in-range responses imply a non-empty view
  a_dims_nz: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.in_range) |->
      (rsp_data.out_rows != '0 && rsp_data.out_cols != '0))
    else $error("in-range response with empty dimensions");

endmodule

`default_nettype wire

>>> dv/tb_bit_matrix_orientation_map_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bit matrix orientation map core.
module tb_bit_matrix_orientation_map_core;
  import bmo_pkg::*;

  localparam int MAX_DIM          = MAX_DIM_DEF;
  localparam int CELLS            = MAX_DIM * MAX_DIM;
  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 12;
  // a read answers via the input and response registers; loads retire from
  // the input register, so quiet cycles pass before touching the configuration
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int RANDOM_PHASES    = 15;
  localparam int ITEMS_PER_PHASE  = 20;
  localparam int TIMEOUT_CYCLES   = 200000;

  // coordinate of the transformed view traced back into the source matrix
  typedef struct {
    bit ok;
    int src_row;
    int src_col;
    int rows_o;
    int cols_o;
  } view_t;

  // one pending request plus an optional "wait until all reads answered"
  typedef struct {
    in_item_t item;
    bit       wait_idle;
  } cell_op_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  in_item_t   req_data = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  out_item_t  rsp_data;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit_matrix_orientation_map_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy as the block sees it; starts at the reset defaults.
  cfg_t shadow_cfg = '{source_rows: 9'd1, source_cols: 9'd1, rotation_deg: 9'd0,
                       bank_select: 2'd0, mirror_x: 1'b0, mirror_y: 1'b0,
                       invert_bits: 1'b0, compat_mode: 1'b0};

  bit        matrix_bits [CELLS];  // source bits as loaded by accepted requests
  bit        cell_loaded [CELLS];  // cells some queued load will have written
  cell_op_t  cell_ops[$];          // requests waiting for the driver
  out_item_t read_answers[$];      // expected responses, oldest first
  bit        req_offered = 1'b0;   // blocking mirror of req_valid
  int        send_gap_pct = 0;
  int        rcv_stall_pct = 0;
  bit        long_hold_req = 1'b0;
  int        hold_left = 0;
  int        mismatches = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("bit_matrix_orientation_map_core: mismatch");
    $finish;
  end

  // Trace an output coordinate back to its source cell: undo the mirrors,
  // then the bank offset, then the rotation. Also gives the view size.
  function automatic view_t map_view(cfg_t c, int r, int k);
    view_t v;
    int    rows, cols, deg, full_cols, vr, vc;
    rot_t  rot;
    rows = (c.source_rows == 0) ? 1 : (c.source_rows > MAX_DIM) ? MAX_DIM : int'(c.source_rows);
    cols = (c.source_cols == 0) ? 1 : (c.source_cols > MAX_DIM) ? MAX_DIM : int'(c.source_cols);
    deg = int'(c.rotation_deg) % int'(DEG_360);
    if (c.compat_mode && c.mirror_x) deg = (deg + int'(DEG_180)) % int'(DEG_360);
    // any angle off the quarter turns behaves as no rotation
    if (deg == int'(DEG_90)) rot = ROT_90;
    else if (deg == int'(DEG_180)) rot = ROT_180;
    else if (deg == int'(DEG_270)) rot = ROT_270;
    else rot = ROT_0;
    if (rot == ROT_90 || rot == ROT_270) begin
      v.rows_o = cols;
      full_cols = rows;
    end else begin
      v.rows_o = rows;
      full_cols = cols;
    end
    // half banks round down; bank code 3 keeps the full width
    v.cols_o = (c.bank_select == BANK_LEFT || c.bank_select == BANK_RIGHT) ?
               full_cols / 2 : full_cols;
    v.ok = (r < v.rows_o) && (k < v.cols_o);
    vr = c.mirror_y ? v.rows_o - 1 - r : r;
    vc = c.mirror_x ? v.cols_o - 1 - k : k;
    if (c.bank_select == BANK_RIGHT) vc = vc + v.cols_o;
    case (rot)
      ROT_90: begin
        v.src_row = full_cols - 1 - vc;
        v.src_col = vr;
      end
      ROT_180: begin
        v.src_row = v.rows_o - 1 - vr;
        v.src_col = full_cols - 1 - vc;
      end
      ROT_270: begin
        v.src_row = vc;
        v.src_col = v.rows_o - 1 - vr;
      end
      default: begin
        v.src_row = vr;
        v.src_col = vc;
      end
    endcase
    return v;
  endfunction

  function automatic cfg_t mk_cfg(int rows, int cols, int deg, int bank,
                                  bit mx, bit my, bit inv, bit compat);
    cfg_t c;
    c.source_rows  = DIM_W'(rows);
    c.source_cols  = DIM_W'(cols);
    c.rotation_deg = DIM_W'(deg);
    c.bank_select  = 2'(bank);
    c.mirror_x     = mx;
    c.mirror_y     = my;
    c.invert_bits  = inv;
    c.compat_mode  = compat;
    return c;
  endfunction

  // Mostly small matrices; now and then zero, full size or oversize.
  function automatic int random_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(MAX_DIM + 1, 511);
      3:       return $urandom_range(13, MAX_DIM - 1);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int random_angle();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 90;
      2:       return 180;
      3:       return 270;
      4:       return 450;  // wraps to a quarter turn
      5:       return 359;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  task automatic add_load(int r, int k, bit b, bit wait_idle);
    cell_op_t op;
    op.item.opcode    = OP_LOAD;
    op.item.row_index = COORD_W'(r);
    op.item.col_index = COORD_W'(k);
    op.item.bit_in    = b;
    op.wait_idle      = wait_idle;
    cell_ops.push_back(op);
    cell_loaded[r * MAX_DIM + k] = 1'b1;
  endtask

  // A read whose source cell is still blank gets a load queued ahead of it,
  // so no request ever reads undefined store contents.
  task automatic add_read(int r, int k, bit wait_idle);
    view_t    v;
    cell_op_t op;
    bit       w;
    v = map_view(shadow_cfg, r, k);
    w = wait_idle;
    if (v.ok && !cell_loaded[v.src_row * MAX_DIM + v.src_col]) begin
      add_load(v.src_row, v.src_col, 1'($urandom_range(0, 1)), w);
      w = 1'b0;
    end
    op.item.opcode    = OP_READ;
    op.item.row_index = COORD_W'(r);
    op.item.col_index = COORD_W'(k);
    op.item.bit_in    = 1'($urandom_range(0, 1));
    op.wait_idle      = w;
    cell_ops.push_back(op);
  endtask

  // Wait until every request is taken and answered, then let loads retire.
  task automatic drain_block();
    while (cell_ops.size() != 0 || req_offered || read_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back; call only with the block idle.
  task automatic apply_cfg(cfg_t c);
    cfg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_SOURCE_ROWS:  cfg_data <= c.source_rows;
        CFG_SOURCE_COLS:  cfg_data <= c.source_cols;
        CFG_ROTATION_DEG: cfg_data <= c.rotation_deg;
        CFG_BANK_SELECT:  cfg_data <= CFG_DATA_W'(c.bank_select);
        CFG_MIRROR_X:     cfg_data <= CFG_DATA_W'(c.mirror_x);
        CFG_MIRROR_Y:     cfg_data <= CFG_DATA_W'(c.mirror_y);
        CFG_INVERT_BITS:  cfg_data <= CFG_DATA_W'(c.invert_bits);
        default:          cfg_data <= CFG_DATA_W'(c.compat_mode);
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  // One directed read under its own configuration.
  task automatic probe_view(cfg_t c, int r, int k);
    apply_cfg(c);
    add_read(r, k, 1'b0);
    drain_block();
  endtask

  // Request driver. Predicts on acceptance: a load updates the bit model,
  // a read queues the expected response. A held request stays put until
  // taken; the next one goes out at the edge that takes the current one.
  always @(posedge clk) begin
    view_t     v;
    out_item_t ans;
    cell_op_t  nxt;
    if (rst) begin
      req_valid   <= 1'b0;
      req_offered = 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        if (req_data.opcode == OP_LOAD) begin
          matrix_bits[int'(req_data.row_index) * MAX_DIM + int'(req_data.col_index)] =
            req_data.bit_in;
        end else begin
          v = map_view(shadow_cfg, req_data.row_index, req_data.col_index);
          ans.in_range = v.ok;
          if (v.ok)
            ans.bit_out = matrix_bits[v.src_row * MAX_DIM + v.src_col] ^ shadow_cfg.invert_bits;
          else
            ans.bit_out = 1'b0;
          ans.out_rows = DIM_W'(v.rows_o);
          ans.out_cols = DIM_W'(v.cols_o);
          read_answers.push_back(ans);
        end
      end
      if (!req_valid || !req_stall) begin
        // a flagged request waits for every outstanding read to come back
        if (cell_ops.size() != 0 && !(cell_ops[0].wait_idle && read_answers.size() != 0) &&
            $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = cell_ops.pop_front();
          req_valid   <= 1'b1;
          req_data    <= nxt.item;
          req_offered = 1'b1;
        end else begin
          req_valid   <= 1'b0;
          req_offered = 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stall. A long hold, when asked for, runs
  // off its own cycle count so the block backs up into the request side.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (read_answers.size() == 0) begin
          $error("response with no read outstanding: %h", rsp_data);
          mismatches++;
        end else begin
          want = read_answers.pop_front();
          if (rsp_data.bit_out !== want.bit_out) begin
            $error("bit_out: expected %0d, actual %0d", want.bit_out, rsp_data.bit_out);
            mismatches++;
          end
          if (rsp_data.in_range !== want.in_range) begin
            $error("in_range: expected %0d, actual %0d", want.in_range, rsp_data.in_range);
            mismatches++;
          end
          if (rsp_data.out_rows !== want.out_rows) begin
            $error("out_rows: expected %0d, actual %0d", want.out_rows, rsp_data.out_rows);
            mismatches++;
          end
          if (rsp_data.out_cols !== want.out_cols) begin
            $error("out_cols: expected %0d, actual %0d", want.out_cols, rsp_data.out_cols);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
      end
    end
  end

  // Stimulus: directed corners first, then randomized phases.
  initial begin
    int  rr, cc, lim_r, lim_c, read_pct;
    bit  hold;
    view_t dims;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct  = 7;
    rcv_stall_pct = 77;

    // Reset defaults: 1x1 source. Far corners of the store are loaded too,
    // which is legal outside the current source size.
    add_load(0, 0, 1'b1, 1'b0);
    add_load(255, 255, 1'b1, 1'b0);
    add_load(255, 0, 1'b0, 1'b0);
    add_read(0, 0, 1'b0);
    add_read(0, 1, 1'b0);      // column just past the edge
    add_read(255, 255, 1'b0);  // both coordinates at their maximum
    drain_block();

    // 2x3 source, every cell loaded, then one read per orientation case
    apply_cfg(mk_cfg(2, 3, 0, 0, 0, 0, 0, 0));
    for (int r = 0; r < 2; r++)
      for (int k = 0; k < 3; k++)
        add_load(r, k, 1'((r + k) % 3 == 0), 1'b0);
    drain_block();
    probe_view(mk_cfg(2, 3, 90, 0, 0, 0, 0, 0), 2, 1);
    probe_view(mk_cfg(2, 3, 180, 0, 0, 0, 0, 0), 1, 2);
    probe_view(mk_cfg(2, 3, 270, 0, 0, 0, 0, 0), 0, 1);
    probe_view(mk_cfg(2, 3, 450, 0, 0, 0, 0, 0), 2, 0);   // wraps past a full turn
    probe_view(mk_cfg(2, 3, 45, 0, 0, 0, 0, 0), 1, 1);    // odd angle acts as none
    probe_view(mk_cfg(2, 3, 90, 0, 1, 0, 0, 1), 1, 0);    // compat flip: 90 becomes 270
    probe_view(mk_cfg(2, 3, 270, 0, 1, 0, 0, 1), 0, 0);   // compat flip wraps to 90
    probe_view(mk_cfg(2, 3, 0, 1, 0, 0, 0, 0), 1, 0);     // left half
    probe_view(mk_cfg(2, 3, 0, 2, 0, 0, 0, 0), 0, 0);     // right half
    probe_view(mk_cfg(2, 3, 0, 3, 0, 0, 0, 0), 1, 2);     // bank code 3 is full width
    probe_view(mk_cfg(2, 3, 0, 0, 1, 1, 1, 0), 0, 0);     // both mirrors, inverted
    probe_view(mk_cfg(0, 1, 0, 1, 0, 0, 0, 0), 0, 0);     // zero rows, single column banked away
    probe_view(mk_cfg(511, 256, 359, 0, 0, 0, 0, 1), 255, 255);  // oversize saturates

    // Random phases: sender idles lightly / receiver heavily, then the
    // reverse, then neither. Phase 2 carries the long receiver hold with a
    // read-heavy mix; phases 7 and 12 pause the sender mid-stream.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      send_gap_pct  = (ph < 5) ? 7 : (ph < 10) ? 77 : 0;
      rcv_stall_pct = (ph < 5) ? 77 : (ph < 10) ? 7 : 0;
      apply_cfg(mk_cfg(random_dim(), random_dim(), random_angle(), $urandom_range(0, 3),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      dims  = map_view(shadow_cfg, 0, 0);
      lim_r = (dims.rows_o > 255) ? 255 : dims.rows_o;
      lim_c = (dims.cols_o > 255) ? 255 : dims.cols_o;
      read_pct = (ph == 2) ? 95 : 70;
      if (ph == 2) long_hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        hold = (n == ITEMS_PER_PHASE / 2) && (ph == 7 || ph == 12);
        if ($urandom_range(0, 99) < read_pct) begin
          // mostly inside the view or one past its edge, sometimes anywhere
          rr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim_r);
          cc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim_c);
          add_read(rr, cc, hold);
        end else if ($urandom_range(0, 1)) begin
          add_load($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom_range(0, 1)), hold);
        end else begin
          add_load($urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                   hold);
        end
      end
      drain_block();
    end

    if (read_answers.size() != 0) begin
      $error("%0d reads never answered", read_answers.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("bit_matrix_orientation_map_core: match");
    else
      $display("bit_matrix_orientation_map_core: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bmo_pkg.sv
rtl/bmo_map.sv
rtl/bmo_store.sv
rtl/bit_matrix_orientation_map_core.sv
dv/tb_bit_matrix_orientation_map_core.sv
